### rtl/elfba_pkg.sv
`timescale 1ns / 1ps

package elfba_pkg;

  localparam int unsigned MAX_BLOCKS = 255;
  localparam int unsigned LINK_AW    = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned OFF_W      = 16;
  localparam int unsigned BB_W       = 13;
  localparam int unsigned CB_W       = 16;
  localparam int unsigned CFG_DW     = 16;
  localparam int unsigned DIV_STEPS  = OFF_W;

  localparam logic [BB_W-1:0] BB_RESET = BB_W'(16);
  localparam logic [CB_W-1:0] CB_RESET = CB_W'(4096);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  localparam logic ACT_ACQUIRE = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  localparam logic REG_BLOCK_BYTES = 1'b0;
  localparam logic REG_CHUNK_BYTES = 1'b1;

  typedef struct packed {
    logic             action;
    logic [OFF_W-1:0] release_offset;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [OFF_W-1:0] block_offset;
    logic [CNT_W-1:0] block_index;
    logic             chunk_unused;
    logic [CNT_W-1:0] free_count;
  } out_t;

  typedef struct packed {
    logic start;
    logic abort;
  } div_ctl_t;

endpackage

### rtl/elfba_div.sv
`timescale 1ns / 1ps

module elfba_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  elfba_pkg::div_ctl_t              ctl_i,
  input  logic [elfba_pkg::OFF_W-1:0]      dividend_i,
  input  logic [elfba_pkg::BB_W-1:0]       divisor_i,
  output logic                             done_o,
  output logic [elfba_pkg::OFF_W-1:0]      quot_o,
  output logic [elfba_pkg::BB_W-1:0]       rem_o
);

  localparam int unsigned CW = $clog2(elfba_pkg::DIV_STEPS);

  logic                          run_q;
  logic                          done_q;
  logic [CW-1:0]                 cnt_q;
  logic [elfba_pkg::OFF_W-1:0]   quot_q;
  logic [elfba_pkg::BB_W-1:0]    rem_q;
  logic [elfba_pkg::BB_W:0]      shifted;
  logic [elfba_pkg::BB_W+1:0]    diff;
  logic                          borrow;

  // one restoring step: shift in the next dividend bit, try to subtract
  assign shifted = {rem_q, quot_q[elfba_pkg::OFF_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor_i};
  assign borrow  = diff[elfba_pkg::BB_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (ctl_i.abort) begin
        run_q  <= 1'b0;
        done_q <= 1'b0;
      end else if (ctl_i.start) begin
        run_q  <= 1'b1;
        done_q <= 1'b0;
        cnt_q  <= '0;
      end else if (run_q) begin
        cnt_q  <= cnt_q + CW'(1);
        run_q  <= (cnt_q != CW'(elfba_pkg::DIV_STEPS - 1));
        done_q <= (cnt_q == CW'(elfba_pkg::DIV_STEPS - 1));
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
    end else if (run_q) begin
      rem_q  <= borrow ? shifted[elfba_pkg::BB_W-1:0] : diff[elfba_pkg::BB_W-1:0];
      quot_q <= {quot_q[elfba_pkg::OFF_W-2:0], ~borrow};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

### rtl/elfba_links.sv
`timescale 1ns / 1ps

module elfba_links (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               clr_i,
  input  logic                               rd_en_i,
  input  logic [elfba_pkg::LINK_AW-1:0]      rd_addr_i,
  output logic [elfba_pkg::LINK_AW-1:0]      rd_data_o,
  input  logic                               wr_en_i,
  input  logic [elfba_pkg::LINK_AW-1:0]      wr_addr_i,
  input  logic [elfba_pkg::LINK_AW-1:0]      wr_data_i
);

  logic [elfba_pkg::LINK_AW-1:0] mem [elfba_pkg::MAX_BLOCKS];
  logic [elfba_pkg::MAX_BLOCKS-1:0] vld_q;
  logic [elfba_pkg::LINK_AW-1:0] rd_word_q;
  logic [elfba_pkg::LINK_AW-1:0] rd_addr_q;
  logic                          rd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clr_i) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_word_q <= mem[rd_addr_i];
      rd_vld_q  <= vld_q[rd_addr_i] & ~clr_i;
      rd_addr_q <= rd_addr_i;
    end
  end

  // an entry never written since format still points at its neighbor
  assign rd_data_o = rd_vld_q ? rd_word_q : rd_addr_q + elfba_pkg::LINK_AW'(1);

endmodule

### rtl/embedded_free_list_block_allocator.sv
`timescale 1ns / 1ps
// channel   direction  handshake                 word
// command   in         start_i, busy_o           cmd_i   (action, release_offset)
// result    out        done_o, one-cycle strobe  res_o   (status .. free_count)
// config    in         cfg_we_i, cfg_idx_i       cfg_data_i
//
// Acquire: link memory read registered on acceptance, then the pop in S_LOOK.
// Release: the result waits on the 16-step shared divider for offset/block size.
// An empty-chunk acquire, or a release rejected before dividing, answers from idle.
// After reset and after every configuration write the block is busy while the same
// divider finds the block count (not for zero block size); links reformat at once.
// Results cannot be held off; busy_o stays high while an item is at work.

module embedded_free_list_block_allocator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  elfba_pkg::in_t                     cmd_i,
  output logic                               done_o,
  output elfba_pkg::out_t                    res_o,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [elfba_pkg::CFG_DW-1:0]       cfg_data_i
);

  typedef enum logic [2:0] {
    S_FORMAT,
    S_COUNT,
    S_IDLE,
    S_LOOK,
    S_DIV
  } state_e;

  state_e                         state_q;
  logic [elfba_pkg::BB_W-1:0]     block_bytes_q;
  logic [elfba_pkg::CB_W-1:0]     chunk_bytes_q;
  logic [elfba_pkg::CNT_W-1:0]    count_q;
  logic [elfba_pkg::CNT_W-1:0]    free_q;
  logic [elfba_pkg::CNT_W-1:0]    used_q;
  logic [elfba_pkg::LINK_AW-1:0]  head_q;
  logic [elfba_pkg::OFF_W-1:0]    off_q;
  logic                           done_q;
  elfba_pkg::out_t                res_q;

  logic                           accept;
  logic                           acq_go;
  logic                           rel_go;
  elfba_pkg::div_ctl_t            div_ctl;
  logic [elfba_pkg::OFF_W-1:0]    div_dividend;
  logic                           div_done;
  logic [elfba_pkg::OFF_W-1:0]    div_quot;
  logic [elfba_pkg::BB_W-1:0]     div_rem;
  logic                           rel_ok;
  logic [elfba_pkg::LINK_AW-1:0]  link_rd;
  logic [elfba_pkg::BB_W+elfba_pkg::CNT_W-1:0] acq_prod;

  assign accept = start_i && (state_q == S_IDLE);
  assign acq_go = accept && (cmd_i.action == elfba_pkg::ACT_ACQUIRE) && (free_q != '0);
  assign rel_go = accept && (cmd_i.action == elfba_pkg::ACT_RELEASE) &&
                  (block_bytes_q != '0) && (used_q != '0);

  assign div_ctl.abort = cfg_we_i;
  assign div_ctl.start = rel_go || ((state_q == S_FORMAT) && (block_bytes_q != '0));
  assign div_dividend  = (state_q == S_FORMAT) ? chunk_bytes_q : cmd_i.release_offset;

  // offset is a block of this chunk: exact multiple and quotient below the count
  assign rel_ok = (div_rem == '0) &&
                  (div_quot < {{(elfba_pkg::OFF_W-elfba_pkg::CNT_W){1'b0}}, count_q});

  assign acq_prod = {{elfba_pkg::BB_W{1'b0}}, head_q} *
                    {{elfba_pkg::CNT_W{1'b0}}, block_bytes_q};

  elfba_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (div_dividend),
    .divisor_i  (block_bytes_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  elfba_links u_links (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (cfg_we_i),
    .rd_en_i   (acq_go),
    .rd_addr_i (head_q),
    .rd_data_o (link_rd),
    .wr_en_i   ((state_q == S_DIV) && div_done && rel_ok && !cfg_we_i),
    .wr_addr_i (div_quot[elfba_pkg::LINK_AW-1:0]),
    .wr_data_i (head_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_FORMAT;
      block_bytes_q <= elfba_pkg::BB_RESET;
      chunk_bytes_q <= elfba_pkg::CB_RESET;
      count_q       <= '0;
      free_q        <= '0;
      used_q        <= '0;
      head_q        <= '0;
      off_q         <= '0;
      done_q        <= 1'b0;
      res_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == elfba_pkg::REG_BLOCK_BYTES) begin
          block_bytes_q <= cfg_data_i[elfba_pkg::BB_W-1:0];
        end else begin
          chunk_bytes_q <= cfg_data_i[elfba_pkg::CB_W-1:0];
        end
        done_q  <= 1'b0;
        state_q <= S_FORMAT;
        count_q <= '0;
        free_q  <= '0;
        used_q  <= '0;
        head_q  <= '0;
      end else begin
        case (state_q)
          S_FORMAT: begin
            done_q  <= 1'b0;
            state_q <= (block_bytes_q == '0) ? S_IDLE : S_COUNT;
          end
          S_COUNT: begin
            done_q <= 1'b0;
            if (div_done) begin
              // clamp the block count to what the 8-bit links can reach
              if (div_quot > elfba_pkg::OFF_W'(elfba_pkg::MAX_BLOCKS)) begin
                count_q <= elfba_pkg::CNT_W'(elfba_pkg::MAX_BLOCKS);
                free_q  <= elfba_pkg::CNT_W'(elfba_pkg::MAX_BLOCKS);
              end else begin
                count_q <= div_quot[elfba_pkg::CNT_W-1:0];
                free_q  <= div_quot[elfba_pkg::CNT_W-1:0];
              end
              state_q <= S_IDLE;
            end
          end
          S_IDLE: begin
            done_q <= accept && !acq_go && !rel_go;
            if (accept) begin
              off_q <= cmd_i.release_offset;
              if (acq_go) begin
                state_q <= S_LOOK;
              end else if (rel_go) begin
                state_q <= S_DIV;
              end else begin
                res_q <= {((cmd_i.action == elfba_pkg::ACT_ACQUIRE) ?
                           elfba_pkg::ST_EMPTY : elfba_pkg::ST_BAD),
                          {elfba_pkg::OFF_W{1'b0}}, {elfba_pkg::CNT_W{1'b0}}, 1'b0,
                          free_q};
              end
            end
          end
          S_LOOK: begin
            // pop the head
            head_q  <= link_rd;
            free_q  <= free_q - elfba_pkg::CNT_W'(1);
            used_q  <= used_q + elfba_pkg::CNT_W'(1);
            done_q  <= 1'b1;
            res_q   <= {elfba_pkg::ST_OK, acq_prod[elfba_pkg::OFF_W-1:0], head_q, 1'b0,
                        free_q - elfba_pkg::CNT_W'(1)};
            state_q <= S_IDLE;
          end
          S_DIV: begin
            done_q <= div_done;
            if (div_done) begin
              if (rel_ok) begin
                // push the released block
                head_q <= div_quot[elfba_pkg::LINK_AW-1:0];
                free_q <= free_q + elfba_pkg::CNT_W'(1);
                used_q <= used_q - elfba_pkg::CNT_W'(1);
                res_q  <= {elfba_pkg::ST_OK, off_q, div_quot[elfba_pkg::CNT_W-1:0],
                           (used_q == elfba_pkg::CNT_W'(1)),
                           free_q + elfba_pkg::CNT_W'(1)};
              end else begin
                res_q  <= {elfba_pkg::ST_BAD, {elfba_pkg::OFF_W{1'b0}},
                           {elfba_pkg::CNT_W{1'b0}}, 1'b0, free_q};
              end
              state_q <= S_IDLE;
            end
          end
          default: begin
            done_q  <= 1'b0;
            state_q <= S_FORMAT;
          end
        endcase
      end
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // every block is either free or in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |->
      (({1'b0, free_q} + {1'b0, used_q}) == {1'b0, count_q}))
    else $error("free and used blocks do not add up to the block count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.chunk_unused) |-> (res_o.free_count == count_q))
    else $error("chunk reported unused while blocks are missing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_COUNT || state_q == S_DIV))
    else $error("divider finished outside a divide state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && block_bytes_q == '0) |-> (count_q == '0))
    else $error("zero block size left a nonzero block count");

endmodule

### verif/embedded_free_list_block_allocator_tb.sv
`timescale 1ns / 1ps

module embedded_free_list_block_allocator_tb;
  import elfba_pkg::*;

  class alloc_scoreboard;
    logic [BB_W-1:0]  block_bytes;
    logic [CB_W-1:0]  chunk_bytes;
    logic [7:0]       next_link [256];
    logic [7:0]       free_head;
    logic [CNT_W-1:0] free_blocks;
    logic [CNT_W-1:0] used_blocks;

    out_t expected_words [$];
    time  accept_stamps [$];
    int   failures;
    int   acquired, released, empties, rejects, unused_hits;

    function new();
      block_bytes = BB_RESET;
      chunk_bytes = CB_RESET;
      failures    = 0;
      acquired    = 0;
      released    = 0;
      empties     = 0;
      rejects     = 0;
      unused_hits = 0;
      format_list();
    endfunction

    function int block_count();
      int n;
      if (block_bytes == 0) return 0;
      n = int'(chunk_bytes) / int'(block_bytes);
      return (n > int'(MAX_BLOCKS)) ? int'(MAX_BLOCKS) : n;
    endfunction

    function void format_list();
      for (int i = 0; i < 256; i++) next_link[i] = 8'(i + 1);
      free_head   = '0;
      free_blocks = CNT_W'(block_count());
      used_blocks = '0;
    endfunction

    function void write_reg(logic idx, logic [CFG_DW-1:0] data);
      if (idx == REG_BLOCK_BYTES) block_bytes = data[BB_W-1:0];
      else chunk_bytes = data[CB_W-1:0];
      format_list();
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // compute the result word of one accepted command and advance the free list
    function out_t predict_word(in_t w);
      out_t r;
      int   n, off, bb;
      logic [7:0] idx;
      r  = '0;
      bb = int'(block_bytes);
      if (w.action == ACT_ACQUIRE) begin
        if (free_blocks == 0) begin
          r.status = ST_EMPTY;
          empties++;
        end else begin
          idx            = free_head;
          r.block_index  = idx;
          r.block_offset = OFF_W'(int'(idx) * bb);
          free_head      = next_link[idx];
          free_blocks    = free_blocks - 1'b1;
          used_blocks    = used_blocks + 1'b1;
          acquired++;
        end
      end else begin
        n   = block_count();
        off = int'(w.release_offset);
        if (n == 0 || used_blocks == 0 || off >= n * bb || (off % bb) != 0) begin
          r.status = ST_BAD;
          rejects++;
        end else begin
          idx             = 8'(off / bb);
          next_link[idx]  = free_head;
          free_head       = idx;
          free_blocks     = free_blocks + 1'b1;
          used_blocks     = used_blocks - 1'b1;
          r.block_index   = idx;
          r.block_offset  = w.release_offset;
          r.chunk_unused  = (used_blocks == 0);
          released++;
          if (r.chunk_unused) unused_hits++;
        end
      end
      r.free_count = free_blocks;
      return r;
    endfunction

    function out_t accept_cmd(in_t w, time now);
      out_t r;
      r = predict_word(w);
      expected_words.push_back(r);
      accept_stamps.push_back(now);
      return r;
    endfunction

    function void check_word(out_t got, time now);
      out_t exp;
      // a word can only answer a command accepted at an earlier edge
      if (expected_words.size() == 0 || accept_stamps[0] >= now) begin
        failures++;
        if (failures <= 10)
          $display("%0t: unexpected result word st=%0d off=%0d idx=%0d unused=%0d free=%0d",
                   now, got.status, got.block_offset, got.block_index, got.chunk_unused,
                   got.free_count);
        return;
      end
      exp = expected_words.pop_front();
      void'(accept_stamps.pop_front());
      if (got.status !== exp.status || got.block_offset !== exp.block_offset ||
          got.block_index !== exp.block_index || got.chunk_unused !== exp.chunk_unused ||
          got.free_count !== exp.free_count) begin
        failures++;
        if (failures <= 10)
          $display("%0t: mismatch exp st=%0d off=%0d idx=%0d unused=%0d free=%0d | got st=%0d off=%0d idx=%0d unused=%0d free=%0d",
                   now, exp.status, exp.block_offset, exp.block_index, exp.chunk_unused,
                   exp.free_count, got.status, got.block_offset, got.block_index,
                   got.chunk_unused, got.free_count);
      end
    endfunction
  endclass

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              start_i    = 1'b0;
  logic              busy_o;
  in_t               cmd_i      = '0;
  logic              done_o;
  out_t              res_o;
  logic              cfg_we_i   = 1'b0;
  logic              cfg_idx_i  = REG_BLOCK_BYTES;
  logic [CFG_DW-1:0] cfg_data_i = '0;

  alloc_scoreboard alloc = new();
  int              held [$];
  int              cfg_writes = 0;
  int              cmds_sent = 0;

  embedded_free_list_block_allocator i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .cmd_i      (cmd_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) alloc.check_word(res_o, $time);
  end

  task automatic send_cmd(input logic act, input logic [OFF_W-1:0] off);
    in_t  w;
    out_t r;
    w.action         = act;
    w.release_offset = off;
    start_i <= 1'b1;
    cmd_i   <= w;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    r = alloc.accept_cmd(w, $time);
    cmds_sent++;
    // track blocks held by the stimulus so releases can target them
    if (r.status == ST_OK) begin
      if (act == ACT_ACQUIRE) begin
        held.push_back(int'(r.block_index));
      end else begin
        foreach (held[j]) begin
          if (held[j] == int'(r.block_index)) begin
            held.delete(j);
            break;
          end
        end
      end
    end
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DW-1:0] data);
    start_i <= 1'b0;
    while (alloc.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    alloc.write_reg(idx, data);
    held.delete();
    cfg_writes++;
    // let the block raise busy for its count pass
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_geometry(input logic [CFG_DW-1:0] bb, input logic [CFG_DW-1:0] cb);
    if ($urandom_range(1) == 0) begin
      write_reg(REG_BLOCK_BYTES, bb);
      write_reg(REG_CHUNK_BYTES, cb);
    end else begin
      write_reg(REG_CHUNK_BYTES, cb);
      write_reg(REG_BLOCK_BYTES, bb);
    end
  endtask

  task automatic sender_gap(input int pct);
    if (pct != 0 && $urandom_range(99) < pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  endtask

  task automatic run_segment(input int items, input int pct);
    int r, j, n, bb;
    logic act;
    logic [OFF_W-1:0] off;
    bit fill;
    for (int k = 0; k < items; k++) begin
      sender_gap(pct);
      n    = alloc.block_count();
      bb   = int'(alloc.block_bytes);
      fill = ((k / 40) % 2) == 0;
      r    = $urandom_range(99);
      off  = OFF_W'($urandom());
      act  = ACT_ACQUIRE;
      if (r < 85) begin
        if (held.size() != 0 && (fill ? r < 25 : r < 65)) begin
          j   = $urandom_range(held.size() - 1);
          act = ACT_RELEASE;
          off = OFF_W'(held[j] * bb);
        end
      end else begin
        act = ACT_RELEASE;
        case ($urandom_range(3))
          1: if (bb > 1) off = OFF_W'($urandom_range(0, 254) * bb + $urandom_range(1, bb - 1));
          2: off = OFF_W'((n + $urandom_range(0, 3)) * bb);
          3: off = OFF_W'($urandom_range(0, (n > 0) ? n - 1 : 0) * bb);
          default: ;
        endcase
      end
      send_cmd(act, off);
    end
  endtask

  initial begin
    int pct;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry: 16-byte blocks, count capped at 255
    send_cmd(ACT_ACQUIRE, 16'hFFFF);
    send_cmd(ACT_ACQUIRE, 16'h0000);
    send_cmd(ACT_RELEASE, 16'd5);
    send_cmd(ACT_RELEASE, 16'hFFFF);
    send_cmd(ACT_RELEASE, 16'd4080);
    send_cmd(ACT_RELEASE, 16'd4064);
    send_cmd(ACT_RELEASE, 16'd16);
    send_cmd(ACT_RELEASE, 16'd0);
    send_cmd(ACT_RELEASE, 16'd0);
    // zero block size: nothing can be acquired or released
    write_reg(REG_BLOCK_BYTES, 16'd0);
    send_cmd(ACT_ACQUIRE, 16'd0);
    send_cmd(ACT_RELEASE, 16'd0);
    // oversized block, upper data bits dropped by the 13-bit register
    set_geometry(16'hFFFF, 16'hFFFF);
    send_cmd(ACT_ACQUIRE, 16'd0);
    send_cmd(ACT_ACQUIRE, 16'd0);
    send_cmd(ACT_RELEASE, 16'd8191);
    send_cmd(ACT_RELEASE, 16'd0);
    // single byte chunk: one block, then empty
    set_geometry(16'd1, 16'd1);
    send_cmd(ACT_ACQUIRE, 16'd0);
    send_cmd(ACT_ACQUIRE, 16'd0);
    send_cmd(ACT_RELEASE, 16'd1);
    send_cmd(ACT_RELEASE, 16'd0);
    set_geometry(16'd4096, 16'd65535);
    send_cmd(ACT_ACQUIRE, 16'hAAAA);
    send_cmd(ACT_ACQUIRE, 16'h5555);
    send_cmd(ACT_RELEASE, 16'd4096);
    send_cmd(ACT_RELEASE, 16'd61440);

    for (int s = 0; s < 10; s++) begin
      case (s)
        0: set_geometry(16'd3, 16'd20);
        1: set_geometry(16'd16, 16'd4096);
        2: set_geometry(16'hE00C, 16'd48);
        3: set_geometry(16'd1, 16'd65535);
        4: set_geometry(16'd4096, 16'd65535);
        5: set_geometry(16'd0, 16'd500);
        6: set_geometry(16'd5000, 16'd65535);
        7: set_geometry(16'd1, 16'd1);
        8: set_geometry(CFG_DW'($urandom_range(1, 64)), CFG_DW'($urandom_range(1, 2000)));
        default: set_geometry(CFG_DW'($urandom_range(1, 4096)), CFG_DW'($urandom()));
      endcase
      pct = (s < 3) ? 28 : (s < 6) ? 52 : 0;
      run_segment(170, pct);
    end

    start_i <= 1'b0;
    while (alloc.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Ran %0d commands under %0d register writes: %0d acquired, %0d released (%0d left chunk unused),",
             cmds_sent, cfg_writes, alloc.acquired, alloc.released, alloc.unused_hits);
    $display("  %0d acquires on an empty chunk, %0d releases rejected, %0d failures.",
             alloc.empties, alloc.rejects, alloc.failures);
    if (alloc.failures == 0 && alloc.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
